FILE: sv/string_hash_intern_table_macros.svh
// Assertion macros for the string hash intern table.
// Used by the top level; no other dependencies.
`ifndef STRING_HASH_INTERN_TABLE_MACROS_SVH
`define STRING_HASH_INTERN_TABLE_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define STRHASH_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while in reset.
`define STRHASH_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/strhash_pkg.sv
// Shared types and constants for the string hash intern table.
// No dependencies.
`timescale 1ns / 1ps

package strhash_pkg;

   localparam int TABLE_DEPTH_DEF = 64;
   localparam int KEY_W           = 32;
   localparam int HANDLE_W        = 16;
   localparam int BYTE_W          = 8;
   localparam int SLOT_W          = 6;

   localparam logic [KEY_W-1:0] POS_A_INIT = 32'd23;
   localparam logic [KEY_W-1:0] POS_B_INIT = 32'd65537;

   localparam logic CMD_CHAR   = 1'b0;
   localparam logic CMD_DIRECT = 1'b1;

   typedef struct packed {
      logic                cmd;
      logic [BYTE_W-1:0]   char_byte;
      logic                last;
      logic [HANDLE_W-1:0] handle;
      logic [KEY_W-1:0]    given_key;
   } req_type;

   typedef struct packed {
      logic [HANDLE_W-1:0] result_handle;
      logic                found;
      logic [SLOT_W-1:0]   entry_index;
      logic                table_full;
      logic [KEY_W-1:0]    key_out;
   } rsp_type;

   // Search token that walks the cell chain.
   typedef struct packed {
      logic                vld;
      logic [KEY_W-1:0]    key;
      logic [HANDLE_W-1:0] handle;
      logic                hit;
      logic                ins;
      logic [SLOT_W-1:0]   slot;
   } probe_type;

endpackage

FILE: sv/strhash_hash.sv
// Character hash pipeline: weight multiply, byte multiply, accumulate.
// Depends on strhash_pkg.
`timescale 1ns / 1ps

module strhash_hash (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [strhash_pkg::BYTE_W-1:0] char_byte,
   input  logic                         last,
   output logic                         done,
   output logic                         key_vld,
   output logic [strhash_pkg::KEY_W-1:0] key
);
   import strhash_pkg::*;

   // pa/pb track pos+23 and pos+65537 directly
   logic [KEY_W-1:0]  pa_ff, pb_ff, acc_ff;
   logic              s1_vld_ff, s2_vld_ff;
   logic              s1_last_ff, s2_last_ff;
   logic [BYTE_W-1:0] s1_byte_ff;
   logic [KEY_W-1:0]  weight_ff, prod_ff;
   logic [KEY_W-1:0]  weight_in, prod_in, sx, sum;

   assign weight_in = pa_ff * pb_ff;
   assign sx        = {{(KEY_W-BYTE_W){s1_byte_ff[BYTE_W-1]}}, s1_byte_ff};
   assign prod_in   = sx * weight_ff;
   assign sum       = acc_ff + prod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         pa_ff     <= POS_A_INIT;
         pb_ff     <= POS_B_INIT;
         acc_ff    <= '0;
      end else begin
         s1_vld_ff <= start;
         s2_vld_ff <= s1_vld_ff;
         if (start) begin
            weight_ff  <= weight_in;
            s1_byte_ff <= char_byte;
            s1_last_ff <= last;
         end
         if (s1_vld_ff) begin
            prod_ff    <= prod_in;
            s2_last_ff <= s1_last_ff;
         end
         if (s2_vld_ff) begin
            if (s2_last_ff) begin
               acc_ff <= '0;
               pa_ff  <= POS_A_INIT;
               pb_ff  <= POS_B_INIT;
            end else begin
               acc_ff <= sum;
               pa_ff  <= pa_ff + 1'b1;
               pb_ff  <= pb_ff + 1'b1;
            end
         end
      end
   end

   assign done    = s2_vld_ff;
   assign key_vld = s2_vld_ff && s2_last_ff;
   assign key     = sum;

endmodule

FILE: sv/strhash_cell.sv
// One table slot: holds a key/handle pair and passes the search token on.
// Depends on strhash_pkg.
`timescale 1ns / 1ps

module strhash_cell #(
   parameter int CNT_W = 7,
   parameter int INDEX = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [CNT_W-1:0]       count,
   input  strhash_pkg::probe_type up_probe,
   output strhash_pkg::probe_type down_probe
);
   import strhash_pkg::*;

   localparam logic [CNT_W-1:0]  MY_INDEX = CNT_W'(INDEX);
   localparam logic [SLOT_W-1:0] MY_SLOT  = SLOT_W'(INDEX);

   logic [KEY_W-1:0]    key_ff;
   logic [HANDLE_W-1:0] handle_ff;
   probe_type           probe_ff, probe_in;
   logic                live, match, take;

   // Slots at or above count are empty; the first empty one takes a miss.
   assign live  = up_probe.vld && !up_probe.hit && !up_probe.ins;
   assign match = live && (MY_INDEX < count) && (key_ff == up_probe.key);
   assign take  = live && (MY_INDEX == count);

   always_comb begin
      probe_in = up_probe;
      if (match) begin
         probe_in.hit    = 1'b1;
         probe_in.slot   = MY_SLOT;
         probe_in.handle = handle_ff;
      end
      if (take) begin
         probe_in.ins  = 1'b1;
         probe_in.slot = MY_SLOT;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         key_ff    <= up_probe.key;
         handle_ff <= up_probe.handle;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         probe_ff.vld <= 1'b0;
      end else begin
         probe_ff <= probe_in;
      end
   end

   assign down_probe = probe_ff;

endmodule

FILE: sv/string_hash_intern_table.sv
// String hash intern table: request/response channels, a hash pipeline and a
// chain of TABLE_DEPTH slot cells that a search token walks one cell a cycle.
//
// req_* carries one request: a string character (cmd 0) or a direct key
// (cmd 1). rsp_* carries one response per lookup: a character marked last or
// a direct command. Non-last characters give no response.
// A non-last character occupies the block through two registered multiplies
// and an accumulate. A direct lookup holds off the next request at least until
// its search token has passed every cell in turn, which sets the lookup time;
// a last character passes the hash pipeline first.
// A miss is written into the first empty cell; when all cells are in use the
// response reports table_full and nothing is stored.
// Reset empties the table (entry count to zero) and clears the hash state.
// The response sits in an output register; while the receiver stalls a new
// request is still taken, and a second finished lookup parks in a holding
// register until the first response is taken.
`timescale 1ns / 1ps
`include "string_hash_intern_table_macros.svh"

module string_hash_intern_table #(
   parameter int TABLE_DEPTH = strhash_pkg::TABLE_DEPTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  strhash_pkg::req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output strhash_pkg::rsp_type rsp_data
);
   import strhash_pkg::*;

   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HASH,
      ST_SEARCH,
      ST_WAIT
   } state_type;

   state_type           state_ff;
   logic [CNT_W-1:0]    count_ff;
   probe_type           head_ff;
   logic [HANDLE_W-1:0] handle_ff;
   logic                rsp_valid_ff;
   rsp_type             rsp_ff, pend_ff, rsp_in;
   probe_type           chain [TABLE_DEPTH+1];
   probe_type           tail;
   logic                accept, rsp_free, rsp_load;
   logic                head_vld_in, rsp_valid_in;
   logic                hash_done, hash_key_vld;
   logic [KEY_W-1:0]    hash_key;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   // A token enters the chain for a direct request or a finished string.
   assign head_vld_in = (accept && (req_data.cmd == CMD_DIRECT)) ||
                        ((state_ff == ST_HASH) && hash_key_vld);
   assign rsp_load    = rsp_free && (((state_ff == ST_SEARCH) && tail.vld) ||
                                     (state_ff == ST_WAIT));
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);

   strhash_hash u_hash (
      .clock     (clock),
      .reset     (reset),
      .start     (accept && (req_data.cmd == CMD_CHAR)),
      .char_byte (req_data.char_byte),
      .last      (req_data.last),
      .done      (hash_done),
      .key_vld   (hash_key_vld),
      .key       (hash_key)
   );

   assign chain[0] = head_ff;

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      strhash_cell #(
         .CNT_W (CNT_W),
         .INDEX (i)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .count      (count_ff),
         .up_probe   (chain[i]),
         .down_probe (chain[i+1])
      );
   end

   assign tail = chain[TABLE_DEPTH];

   // A token that neither hit nor found an empty cell means the table is full.
   always_comb begin
      rsp_in.result_handle = tail.handle;
      rsp_in.found         = tail.hit;
      rsp_in.entry_index   = tail.slot;
      rsp_in.table_full    = !tail.hit && !tail.ins;
      rsp_in.key_out       = tail.key;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         head_ff.vld  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff.vld  <= head_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  handle_ff <= req_data.handle;
                  if (req_data.cmd == CMD_DIRECT) begin
                     head_ff.key    <= req_data.given_key;
                     head_ff.handle <= req_data.handle;
                     head_ff.hit    <= 1'b0;
                     head_ff.ins    <= 1'b0;
                     head_ff.slot   <= '0;
                     state_ff       <= ST_SEARCH;
                  end else begin
                     state_ff <= ST_HASH;
                  end
               end
            end
            ST_HASH: begin
               if (hash_done) begin
                  if (hash_key_vld) begin
                     head_ff.key    <= hash_key;
                     head_ff.handle <= handle_ff;
                     head_ff.hit    <= 1'b0;
                     head_ff.ins    <= 1'b0;
                     head_ff.slot   <= '0;
                     state_ff       <= ST_SEARCH;
                  end else begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            ST_SEARCH: begin
               if (tail.vld) begin
                  if (tail.ins) begin
                     count_ff <= count_ff + 1'b1;
                  end
                  if (rsp_free) begin
                     rsp_ff   <= rsp_in;
                     state_ff <= ST_IDLE;
                  end else begin
                     pend_ff  <= rsp_in;
                     state_ff <= ST_WAIT;
                  end
               end
            end
            ST_WAIT: begin
               if (rsp_free) begin
                  rsp_ff   <= pend_ff;
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `STRHASH_ASSERT_IMP(a_count_bound, clock, reset, 1'b1,
      count_ff <= CNT_W'(TABLE_DEPTH), "entry count beyond table depth")
   `STRHASH_ASSERT_IMP(a_tail_state, clock, reset, tail.vld,
      state_ff == ST_SEARCH && !(tail.hit && tail.ins),
      "search token out of place or both hit and inserted")
   `STRHASH_ASSERT_IMP(a_hash_state, clock, reset, hash_done,
      state_ff == ST_HASH, "hash result outside hash state")
   `STRHASH_ASSERT_NXT(a_count_step, clock, reset, tail.vld && tail.ins,
      count_ff == CNT_W'($past(count_ff) + 1'b1), "insert did not bump entry count")

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for string_hash_intern_table. It sends strings and direct keys
// and checks each response against a local model of the hash and the key table.
// Depends on strhash_pkg and the string_hash_intern_table RTL.

module tb_top;
   import strhash_pkg::*;

   localparam int DEPTH        = TABLE_DEPTH_DEF;
   localparam int IDLE_PCT     = 36;
   localparam int RANDOM_ITEMS = 800;
   localparam int STEADY_ITEMS = 150;
   localparam int POOL_SIZE    = 16;
   localparam int MAX_LEN      = 8;
   localparam int MAX_REPORTS  = 10;
   localparam int STALL_LIMIT  = 4000;
   localparam int DRAIN_CYCLES = DEPTH + 16;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   string_hash_intern_table #(.TABLE_DEPTH(DEPTH)) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // Local copy of the table and the running hash
   logic [KEY_W-1:0]    table_keys [DEPTH];
   logic [HANDLE_W-1:0] table_handles [DEPTH];
   int                  table_count = 0;
   logic [KEY_W-1:0]    hash_acc = '0;
   logic [KEY_W-1:0]    char_pos = '0;
   rsp_type             pending_lookups [$];
   logic [KEY_W-1:0]    seen_keys [$];

   logic [BYTE_W-1:0]   string_pool [POOL_SIZE][MAX_LEN];
   int                  pool_len [POOL_SIZE];
   int                  pool_used = 0;

   bit steady = 1'b0;
   int n_requests = 0;
   int n_results = 0;
   int n_hits = 0;
   int n_full = 0;
   int n_errors = 0;
   int quiet_cycles = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic rsp_type intern_key(input logic [KEY_W-1:0] key,
                                          input logic [HANDLE_W-1:0] offered);
      rsp_type r;
      r = '0;
      r.result_handle = offered;
      r.key_out = key;
      for (int i = 0; i < table_count; i++) begin
         if (!r.found && table_keys[i] == key) begin
            r.found = 1'b1;
            r.entry_index = SLOT_W'(i);
            r.result_handle = table_handles[i];
         end
      end
      if (!r.found) begin
         if (table_count < DEPTH) begin
            table_keys[table_count] = key;
            table_handles[table_count] = offered;
            r.entry_index = SLOT_W'(table_count);
            table_count++;
         end else begin
            r.table_full = 1'b1;
         end
      end
      seen_keys.push_back(key);
      return r;
   endfunction

   function automatic void predict_request(input req_type r);
      logic [KEY_W-1:0] sx;
      logic [KEY_W-1:0] weight;
      if (r.cmd == CMD_DIRECT) begin
         pending_lookups.push_back(intern_key(r.given_key, r.handle));
      end else begin
         sx = {{(KEY_W-BYTE_W){r.char_byte[BYTE_W-1]}}, r.char_byte};
         weight = (char_pos + POS_A_INIT) * (char_pos + POS_B_INIT);
         hash_acc = hash_acc + sx * weight;
         char_pos = char_pos + 1;
         if (r.last) begin
            pending_lookups.push_back(intern_key(hash_acc, r.handle));
            hash_acc = '0;
            char_pos = '0;
         end
      end
   endfunction

   function automatic void flag_error(input string what, input rsp_type want,
                                      input rsp_type got);
      n_errors++;
      if (n_errors <= MAX_REPORTS)
         $display("%0t ERROR %s: exp handle %h found %b idx %0d full %b key %h",
                  $time, what, want.result_handle, want.found, want.entry_index,
                  want.table_full, want.key_out,
                  "\n    got handle %h found %b idx %0d full %b key %h",
                  got.result_handle, got.found, got.entry_index, got.table_full,
                  got.key_out);
   endfunction

   // Keeps valid high across back-to-back requests; only lowers it for a gap
   task automatic send_request(input req_type r);
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_request(r);
      n_requests++;
   endtask

   task automatic send_char(input logic [BYTE_W-1:0] ch, input logic last,
                            input logic [HANDLE_W-1:0] handle);
      req_type r;
      r.cmd = CMD_CHAR;
      r.char_byte = ch;
      r.last = last;
      r.handle = handle;
      r.given_key = $urandom;
      send_request(r);
   endtask

   task automatic send_direct(input logic [KEY_W-1:0] key,
                              input logic [HANDLE_W-1:0] handle);
      req_type r;
      r.cmd = CMD_DIRECT;
      r.char_byte = BYTE_W'($urandom_range(255));
      r.last = 1'($urandom_range(1));
      r.handle = handle;
      r.given_key = key;
      send_request(r);
   endtask

   task automatic test_directed_strings();
      send_char(8'h41, 1'b1, 16'h0000);
      // sign extension at both ends, and a zero character mid-string
      send_char(8'h7f, 1'b0, 16'h0000);
      send_char(8'h80, 1'b0, 16'h0000);
      send_char(8'hff, 1'b0, 16'h0000);
      send_char(8'h00, 1'b0, 16'h0000);
      send_char(8'h01, 1'b1, 16'hffff);
      send_char(8'h00, 1'b1, 16'h1234);
      send_char(8'h41, 1'b1, 16'h5555);
   endtask

   task automatic test_direct_keys();
      send_direct(32'h0000_0000, 16'hffff);
      send_direct(32'hffff_ffff, 16'h0000);
      send_direct(32'hffff_ffff, 16'haaaa);
      send_direct(seen_keys[1], 16'h0f0f);
      // direct lookup in the middle of a string must not disturb its hash
      send_char(8'h68, 1'b0, 16'h1111);
      send_direct(32'hdead_beef, 16'h2222);
      send_char(8'h69, 1'b1, 16'h3333);
      send_char(8'h68, 1'b0, 16'h4444);
      send_char(8'h69, 1'b1, 16'h6666);
   endtask

   task automatic test_random_traffic();
      int n;
      int len;
      int slot;
      logic [BYTE_W-1:0] ch;
      n = 0;
      steady = 1'b1;
      while (n < RANDOM_ITEMS) begin
         if (n >= STEADY_ITEMS)
            steady = 1'b0;
         if ($urandom_range(99) < 20) begin
            if ($urandom_range(1) && seen_keys.size() > 0)
               send_direct(seen_keys[$urandom_range(seen_keys.size() - 1)],
                           HANDLE_W'($urandom));
            else
               send_direct($urandom, HANDLE_W'($urandom));
            n++;
         end else begin
            if (pool_used > 0 && $urandom_range(1)) begin
               slot = $urandom_range(pool_used - 1);
            end else begin
               slot = (pool_used < POOL_SIZE) ? pool_used : $urandom_range(POOL_SIZE - 1);
               if (pool_used < POOL_SIZE)
                  pool_used++;
               pool_len[slot] = $urandom_range(1, MAX_LEN);
               for (int i = 0; i < pool_len[slot]; i++) begin
                  ch = BYTE_W'($urandom_range(255));
                  if ($urandom_range(9) == 0)
                     ch = '0;
                  string_pool[slot][i] = ch;
               end
            end
            len = pool_len[slot];
            for (int i = 0; i < len; i++) begin
               if (i > 0 && $urandom_range(99) < 8) begin
                  send_direct($urandom, HANDLE_W'($urandom));
                  n++;
               end
               send_char(string_pool[slot][i], i == len - 1, HANDLE_W'($urandom));
               n++;
            end
         end
      end
      steady = 1'b0;
   endtask

   task automatic test_table_full();
      while (table_count < DEPTH)
         send_direct($urandom, HANDLE_W'($urandom));
      repeat (6) send_direct($urandom, HANDLE_W'($urandom));
      repeat (4) send_direct(table_keys[$urandom_range(DEPTH - 1)], HANDLE_W'($urandom));
      send_char(BYTE_W'($urandom_range(255)), 1'b0, HANDLE_W'($urandom));
      send_char(BYTE_W'($urandom_range(255)), 1'b1, HANDLE_W'($urandom));
      send_direct(table_keys[DEPTH - 1], 16'h0000);
   endtask

   always @(posedge clock)
      rsp_ready <= steady || ($urandom_range(99) >= IDLE_PCT);

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         n_results++;
         if (rsp_data.found)
            n_hits++;
         if (rsp_data.table_full)
            n_full++;
         if (pending_lookups.size() == 0) begin
            flag_error("response with no lookup pending", '0, rsp_data);
         end else begin
            want = pending_lookups.pop_front();
            if (rsp_data.result_handle !== want.result_handle ||
                rsp_data.found !== want.found ||
                rsp_data.entry_index !== want.entry_index ||
                rsp_data.table_full !== want.table_full ||
                rsp_data.key_out !== want.key_out)
               flag_error("response mismatch", want, rsp_data);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t ERROR watchdog: no handshake for %0d cycles", $time, STALL_LIMIT);
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_directed_strings();
      test_direct_keys();
      test_random_traffic();
      test_table_full();
      req_valid <= 1'b0;

      while (pending_lookups.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d requests; checked %0d lookups: %0d hits, %0d refused on a full table.",
               n_requests, n_results, n_hits, n_full);
      $display("Table ended with %0d of %0d slots in use; %0d mismatches.",
               table_count, DEPTH, n_errors);
      if (n_errors == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
